// ===== design/spse_pkg.sv =====
// spse_pkg: shared types, widths and codes of the shortest path search engine
`default_nettype none
package spse_pkg;

   localparam int NODE_W   = 10;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 27;
   localparam int KEY_W    = DIST_W + NODE_W;
   localparam int STATUS_W = 2;
   localparam int OP_W     = 2;

   localparam int DEF_NODE_COUNT = 1024;
   localparam int DEF_MAX_DEGREE = 8;

   localparam logic [DIST_W-1:0] UNREACHED = 27'h7ffffff;
   localparam logic [DIST_W-1:0] SUM_CAP   = 27'h7fffffe;

   // operation codes
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNREACH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOPRED  = 2'd3;

   typedef struct packed {
      logic              valid;
      logic [NODE_W-1:0] pred;
      logic [DIST_W-1:0] path_dist;
   } node_word_type;

   typedef struct packed {
      logic [NODE_W-1:0]   target;
      logic [WEIGHT_W-1:0] weight;
   } adj_word_type;

   typedef struct packed {
      logic             clear;
      logic             push;
      logic             pop;
      logic [KEY_W-1:0] key;
   } heap_cmd_type;

   typedef struct packed {
      logic busy;
      logic empty;
   } heap_stat_type;

endpackage
`default_nettype wire

// ===== design/spse_if.sv =====
// spse_if: request and response channel interfaces
`default_nettype none
interface spse_req_if
   import spse_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [NODE_W-1:0]   first_node;
   logic [NODE_W-1:0]   second_node;
   logic [WEIGHT_W-1:0] edge_weight;

   modport source (output valid, operation, first_node, second_node, edge_weight,
                   input ready);
   modport sink   (input valid, operation, first_node, second_node, edge_weight,
                   output ready);
endinterface

interface spse_rsp_if
   import spse_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [NODE_W-1:0]   node_out;
   logic [DIST_W-1:0]   distance;

   modport source (output valid, status, node_out, distance, input ready);
   modport sink   (input valid, status, node_out, distance, output ready);
endinterface
`default_nettype wire

// ===== design/shortest_path_search_engine.sv =====
// shortest_path_search_engine: graph store and dijkstra search sequencer
//
//  channel  | direction | payload                                          | handshake
//  req_ch   | in        | operation, first_node, second_node, edge_weight  | valid/ready
//  rsp_ch   | out       | status, node_out, distance                       | valid/ready
//
// - one request is worked on at a time; req_ch.ready is high only while idle
// - clear graph: a sweep of the degree memory
// - add edge: a degree read, then the slot and degree writes; read predecessor: a node read
// - search: a sweep of the node table, then per pop a heap pop with its sift-down, per
//   edge an adjacency read, a node table read and a heap sift-up; the one read port of the
//   heap memory and the node table read port set the pace
// - after reset a sweep initialises the degree and node tables; no request is taken
//   until it ends
// - the result sits in an output register, so a stalled rsp_ch never blocks the sequencer
//   past its final state
`default_nettype none
module shortest_path_search_engine
   import spse_pkg::*;
#(
   parameter int NODE_COUNT = DEF_NODE_COUNT,
   parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
   input wire logic  clock,
   input wire logic  reset,
   spse_req_if.sink  req_ch,
   spse_rsp_if.source rsp_ch
);
   localparam int NIDX_W     = $clog2(NODE_COUNT);
   localparam int SLOT_COUNT = NODE_COUNT * MAX_DEGREE;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int HEAP_DEPTH = SLOT_COUNT + 1;
   localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
   localparam int NWORD_W    = $bits(node_word_type);
   localparam int AWORD_W    = $bits(adj_word_type);

   // sequencer states
   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_CLRG   = 4'd2;
   localparam logic [3:0] S_ADD1   = 4'd3;
   localparam logic [3:0] S_RD1    = 4'd4;
   localparam logic [3:0] S_SCLR   = 4'd5;
   localparam logic [3:0] S_SINIT  = 4'd6;
   localparam logic [3:0] S_POP    = 4'd7;
   localparam logic [3:0] S_POPW   = 4'd8;
   localparam logic [3:0] S_CHK    = 4'd9;
   localparam logic [3:0] S_EDGE0  = 4'd10;
   localparam logic [3:0] S_EDGE1  = 4'd11;
   localparam logic [3:0] S_EDGE2  = 4'd12;
   localparam logic [3:0] S_FIN0   = 4'd13;
   localparam logic [3:0] S_FIN1   = 4'd14;
   localparam logic [3:0] S_RESULT = 4'd15;

   logic [3:0]          state_ff, state_in;
   logic [NIDX_W-1:0]   sweep_ff, sweep_in;
   logic [NODE_W-1:0]   a_ff, a_in;
   logic [NODE_W-1:0]   b_ff, b_in;
   logic [WEIGHT_W-1:0] w_ff, w_in;
   logic [NODE_W-1:0]   u_ff, u_in;
   logic [DIST_W-1:0]   d_ff, d_in;
   logic [DIST_W-1:0]   du_ff, du_in;
   logic [DEG_W-1:0]    deg_ff, deg_in;
   logic [DEG_W-1:0]    k_ff, k_in;
   logic [NODE_W-1:0]   v_ff, v_in;
   logic [DIST_W-1:0]   sum_ff, sum_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [NODE_W-1:0]   res_node_ff, res_node_in;
   logic [DIST_W-1:0]   res_dist_ff, res_dist_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0]   rsp_node_ff, rsp_node_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;

   // memory ports
   logic                deg_wr_en;
   logic [NIDX_W-1:0]   deg_wr_addr, deg_rd_addr;
   logic [DEG_W-1:0]    deg_wr_data, deg_rd_data;
   logic                node_wr_en;
   logic [NIDX_W-1:0]   node_wr_addr, node_rd_addr;
   node_word_type       node_wr_word, node_rd_word;
   logic [NWORD_W-1:0]  node_rd_raw;
   logic                adj_wr_en;
   logic [SLOT_W-1:0]   adj_wr_addr, adj_rd_addr;
   adj_word_type        adj_wr_word, adj_rd_word;
   logic [AWORD_W-1:0]  adj_rd_raw;

   heap_cmd_type        heap_cmd;
   heap_stat_type       heap_stat;
   logic [KEY_W-1:0]    heap_top;

   logic                req_fire;
   logic                a_ok, b_ok;
   logic                sweep_last;
   logic [DIST_W:0]     sum_wide;

   spse_ram #(.WIDTH(DEG_W), .DEPTH(NODE_COUNT)) u_deg_ram (
      .clock   (clock),
      .wr_en   (deg_wr_en),
      .wr_addr (deg_wr_addr),
      .wr_data (deg_wr_data),
      .rd_addr (deg_rd_addr),
      .rd_data (deg_rd_data)
   );

   // distance, predecessor and its valid flag share one word per node
   spse_ram #(.WIDTH(NWORD_W), .DEPTH(NODE_COUNT)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr_word),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_raw)
   );

   // edge slots, MAX_DEGREE per source node
   spse_ram #(.WIDTH(AWORD_W), .DEPTH(SLOT_COUNT)) u_adj_ram (
      .clock   (clock),
      .wr_en   (adj_wr_en),
      .wr_addr (adj_wr_addr),
      .wr_data (adj_wr_word),
      .rd_addr (adj_rd_addr),
      .rd_data (adj_rd_raw)
   );

   spse_heap #(.DEPTH(HEAP_DEPTH)) u_spse_heap (
      .clock   (clock),
      .reset   (reset),
      .cmd     (heap_cmd),
      .stat    (heap_stat),
      .top_key (heap_top)
   );

   assign node_rd_word = node_word_type'(node_rd_raw);
   assign adj_rd_word  = adj_word_type'(adj_rd_raw);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign a_ok         = 32'(req_ch.first_node) < NODE_COUNT;
   assign b_ok         = 32'(req_ch.second_node) < NODE_COUNT;
   assign sweep_last   = (sweep_ff == NIDX_W'(NODE_COUNT - 1));

   // path sum, saturating one below the unreached marker
   assign sum_wide = {1'b0, du_ff} + (DIST_W + 1)'(adj_rd_word.weight);

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      w_in          = w_ff;
      u_in          = u_ff;
      d_in          = d_ff;
      du_in         = du_ff;
      deg_in        = deg_ff;
      k_in          = k_ff;
      v_in          = v_ff;
      sum_in        = sum_ff;
      res_status_in = res_status_ff;
      res_node_in   = res_node_ff;
      res_dist_in   = res_dist_ff;

      deg_wr_en     = 1'b0;
      deg_wr_addr   = sweep_ff;
      deg_wr_data   = '0;
      deg_rd_addr   = NIDX_W'(u_ff);
      node_wr_en    = 1'b0;
      node_wr_addr  = sweep_ff;
      node_wr_word  = '{valid: 1'b0, pred: '0, path_dist: UNREACHED};
      node_rd_addr  = NIDX_W'(u_ff);
      adj_wr_en     = 1'b0;
      adj_wr_addr   = SLOT_W'(32'(a_ff) * MAX_DEGREE + 32'(deg_rd_data));
      adj_wr_word   = '{target: b_ff, weight: w_ff};
      adj_rd_addr   = SLOT_W'(32'(u_ff) * MAX_DEGREE + 32'(k_ff));
      heap_cmd      = '{clear: 1'b0, push: 1'b0, pop: 1'b0, key: {sum_ff, v_ff}};

      case (state_ff)
         S_INIT: begin
            // power-up sweep of degree and node tables
            deg_wr_en  = 1'b1;
            node_wr_en = 1'b1;
            sweep_in   = sweep_ff + NIDX_W'(1);
            if (sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               a_in          = req_ch.first_node;
               b_in          = req_ch.second_node;
               w_in          = req_ch.edge_weight;
               sweep_in      = '0;
               res_status_in = ST_OK;
               res_node_in   = '0;
               res_dist_in   = '0;
               case (req_ch.operation)
                  OP_CLEAR: begin
                     state_in = S_CLRG;
                  end
                  OP_ADD: begin
                     if (!a_ok || !b_ok) begin
                        res_status_in = ST_FULL;
                        state_in      = S_RESULT;
                     end else begin
                        deg_rd_addr = NIDX_W'(req_ch.first_node);
                        state_in    = S_ADD1;
                     end
                  end
                  OP_SEARCH: begin
                     if (!a_ok || !b_ok) begin
                        res_status_in = ST_UNREACH;
                        res_dist_in   = UNREACHED;
                        state_in      = S_RESULT;
                     end else begin
                        state_in = S_SCLR;
                     end
                  end
                  OP_READ: begin
                     if (!a_ok) begin
                        res_status_in = ST_NOPRED;
                        res_dist_in   = UNREACHED;
                        state_in      = S_RESULT;
                     end else begin
                        node_rd_addr = NIDX_W'(req_ch.first_node);
                        state_in     = S_RD1;
                     end
                  end
                  default: begin
                     state_in = S_RESULT;
                  end
               endcase
            end
         end
         S_CLRG: begin
            deg_wr_en = 1'b1;
            sweep_in  = sweep_ff + NIDX_W'(1);
            if (sweep_last) begin
               state_in = S_RESULT;
            end
         end
         S_ADD1: begin
            if (32'(deg_rd_data) >= MAX_DEGREE) begin
               res_status_in = ST_FULL;
            end else begin
               adj_wr_en   = 1'b1;
               deg_wr_en   = 1'b1;
               deg_wr_addr = NIDX_W'(a_ff);
               deg_wr_data = deg_rd_data + DEG_W'(1);
            end
            state_in = S_RESULT;
         end
         S_RD1: begin
            res_dist_in = node_rd_word.path_dist;
            if (node_rd_word.valid) begin
               res_node_in = node_rd_word.pred;
            end else begin
               res_status_in = ST_NOPRED;
            end
            state_in = S_RESULT;
         end
         S_SCLR: begin
            // every node back to unreached with no predecessor, heap emptied
            node_wr_en     = 1'b1;
            heap_cmd.clear = 1'b1;
            sweep_in       = sweep_ff + NIDX_W'(1);
            if (sweep_last) begin
               state_in = S_SINIT;
            end
         end
         S_SINIT: begin
            node_wr_en    = 1'b1;
            node_wr_addr  = NIDX_W'(a_ff);
            node_wr_word  = '{valid: 1'b0, pred: '0, path_dist: '0};
            heap_cmd.push = 1'b1;
            heap_cmd.key  = {{DIST_W{1'b0}}, a_ff};
            state_in      = S_POP;
         end
         S_POP: begin
            if (!heap_stat.busy) begin
               if (heap_stat.empty) begin
                  state_in = S_FIN0;
               end else begin
                  heap_cmd.pop = 1'b1;
                  state_in     = S_POPW;
               end
            end
         end
         S_POPW: begin
            if (!heap_stat.busy) begin
               u_in = heap_top[NODE_W-1:0];
               d_in = heap_top[KEY_W-1:NODE_W];
               if (heap_top[NODE_W-1:0] == b_ff) begin
                  // target popped: stop here
                  state_in = S_FIN0;
               end else begin
                  node_rd_addr = NIDX_W'(heap_top[NODE_W-1:0]);
                  deg_rd_addr  = NIDX_W'(heap_top[NODE_W-1:0]);
                  state_in     = S_CHK;
               end
            end
         end
         S_CHK: begin
            // stale entry when its distance is above the table
            if (d_ff > node_rd_word.path_dist) begin
               state_in = S_POP;
            end else begin
               du_in    = node_rd_word.path_dist;
               deg_in   = deg_rd_data;
               k_in     = '0;
               state_in = S_EDGE0;
            end
         end
         S_EDGE0: begin
            if (!heap_stat.busy) begin
               if (k_ff >= deg_ff) begin
                  state_in = S_POP;
               end else begin
                  state_in = S_EDGE1;
               end
            end
         end
         S_EDGE1: begin
            v_in = adj_rd_word.target;
            if (sum_wide > (DIST_W + 1)'(SUM_CAP)) begin
               sum_in = SUM_CAP;
            end else begin
               sum_in = sum_wide[DIST_W-1:0];
            end
            node_rd_addr = NIDX_W'(adj_rd_word.target);
            state_in     = S_EDGE2;
         end
         S_EDGE2: begin
            // relax on strict decrease only
            if (32'(v_ff) < NODE_COUNT && sum_ff < node_rd_word.path_dist) begin
               node_wr_en    = 1'b1;
               node_wr_addr  = NIDX_W'(v_ff);
               node_wr_word  = '{valid: 1'b1, pred: u_ff, path_dist: sum_ff};
               heap_cmd.push = 1'b1;
            end
            k_in     = k_ff + DEG_W'(1);
            state_in = S_EDGE0;
         end
         S_FIN0: begin
            node_rd_addr = NIDX_W'(b_ff);
            state_in     = S_FIN1;
         end
         S_FIN1: begin
            if (node_rd_word.path_dist < UNREACHED) begin
               res_status_in = ST_OK;
               res_dist_in   = node_rd_word.path_dist;
            end else begin
               res_status_in = ST_UNREACH;
               res_dist_in   = UNREACHED;
            end
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_dist_in   = rsp_dist_ff;
      if (state_ff == S_RESULT && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_node_in   = res_node_ff;
         rsp_dist_in   = res_dist_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff          <= a_in;
      b_ff          <= b_in;
      w_ff          <= w_in;
      u_ff          <= u_in;
      d_ff          <= d_in;
      du_ff         <= du_in;
      deg_ff        <= deg_in;
      k_ff          <= k_in;
      v_ff          <= v_in;
      sum_ff        <= sum_in;
      res_status_ff <= res_status_in;
      res_node_ff   <= res_node_in;
      res_dist_ff   <= res_dist_in;
      rsp_status_ff <= rsp_status_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_dist_ff   <= rsp_dist_in;
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.node_out = rsp_node_ff;
   assign rsp_ch.distance = rsp_dist_ff;
endmodule
`default_nettype wire

// ===== design/spse_ram.sv =====
// spse_ram: generic single write, single read memory with registered read
`default_nettype none
module spse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== design/spse_heap.sv =====
// spse_heap: binary min-heap of search keys held in one memory
`default_nettype none
module spse_heap
   import spse_pkg::*;
#(
   parameter int DEPTH = DEF_NODE_COUNT * DEF_MAX_DEGREE + 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire heap_cmd_type  cmd,
   output      heap_stat_type stat,
   output      logic [KEY_W-1:0] top_key
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   localparam logic [3:0] H_IDLE = 4'd0;
   localparam logic [3:0] H_POP1 = 4'd1;
   localparam logic [3:0] H_POP2 = 4'd2;
   localparam logic [3:0] H_SD0  = 4'd3;
   localparam logic [3:0] H_SD1  = 4'd4;
   localparam logic [3:0] H_SD2  = 4'd5;
   localparam logic [3:0] H_SD3  = 4'd6;
   localparam logic [3:0] H_UP0  = 4'd7;
   localparam logic [3:0] H_UP1  = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [AW-1:0]    child_ff, child_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] cval_ff, cval_in;
   logic [KEY_W-1:0] top_ff, top_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [KEY_W-1:0] wr_data, rd_data;

   logic [KEY_W-1:0] sel_key;
   logic [AW-1:0]    sel_idx;
   logic [AW-1:0]    up_idx;
   logic             has_left;
   logic             has_right;

   spse_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign up_idx    = AW'((idx_ff - AW'(1)) >> 1);
   assign has_left  = (32'(idx_ff) * 2 + 1) < 32'(count_ff);
   assign has_right = (32'(child_ff) + 1) < 32'(count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      child_in = child_ff;
      key_in   = key_ff;
      cval_in  = cval_ff;
      top_in   = top_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = key_ff;
      rd_addr  = '0;
      sel_key  = cval_ff;
      sel_idx  = child_ff;
      case (state_ff)
         H_IDLE: begin
            if (cmd.clear) begin
               count_in = '0;
            end else if (cmd.pop) begin
               rd_addr  = '0;
               count_in = count_ff - CW'(1);
               state_in = H_POP1;
            end else if (cmd.push) begin
               if (32'(count_ff) < DEPTH) begin
                  idx_in   = AW'(count_ff);
                  key_in   = cmd.key;
                  count_in = count_ff + CW'(1);
                  state_in = H_UP0;
               end
            end
         end
         H_POP1: begin
            top_in = rd_data;
            if (count_ff == '0) begin
               state_in = H_IDLE;
            end else begin
               rd_addr  = AW'(count_ff);
               state_in = H_POP2;
            end
         end
         H_POP2: begin
            key_in   = rd_data;
            idx_in   = '0;
            state_in = H_SD0;
         end
         H_SD0: begin
            if (!has_left) begin
               wr_en    = 1'b1;
               state_in = H_IDLE;
            end else begin
               child_in = AW'(32'(idx_ff) * 2 + 1);
               rd_addr  = AW'(32'(idx_ff) * 2 + 1);
               state_in = H_SD1;
            end
         end
         H_SD1: begin
            cval_in = rd_data;
            if (has_right) begin
               rd_addr  = child_ff + AW'(1);
               state_in = H_SD2;
            end else begin
               state_in = H_SD3;
            end
         end
         H_SD2, H_SD3: begin
            if (state_ff == H_SD2 && rd_data < cval_ff) begin
               sel_key = rd_data;
               sel_idx = child_ff + AW'(1);
            end
            wr_en = 1'b1;
            if (key_ff <= sel_key) begin
               state_in = H_IDLE;
            end else begin
               wr_data  = sel_key;
               idx_in   = sel_idx;
               state_in = H_SD0;
            end
         end
         H_UP0: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               state_in = H_IDLE;
            end else begin
               rd_addr  = up_idx;
               state_in = H_UP1;
            end
         end
         H_UP1: begin
            wr_en = 1'b1;
            if (rd_data <= key_ff) begin
               state_in = H_IDLE;
            end else begin
               wr_data  = rd_data;
               idx_in   = up_idx;
               state_in = H_UP0;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff   <= idx_in;
      child_ff <= child_in;
      key_ff   <= key_in;
      cval_ff  <= cval_in;
      top_ff   <= top_in;
   end

   assign stat.busy  = (state_ff != H_IDLE);
   assign stat.empty = (count_ff == '0);
   assign top_key    = top_ff;
endmodule
`default_nettype wire

// ===== design/spse_checker.sv =====
// spse_checker: port-level assertions for the shortest path search engine
`default_nettype none
module spse_checker
   import spse_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [NODE_W-1:0]   rsp_node_out,
   input wire logic [DIST_W-1:0]   rsp_distance
);
   // a held response stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in flight");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // full status carries no node and no distance
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_node_out == '0 && rsp_distance == '0)
      else $error("full status with payload");

   // unreachable status always carries the marker
   a_unreach_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_UNREACH |-> rsp_distance == UNREACHED)
      else $error("unreachable without marker");
endmodule

bind shortest_path_search_engine spse_checker u_spse_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_status   (rsp_ch.status),
   .rsp_node_out (rsp_ch.node_out),
   .rsp_distance (rsp_ch.distance)
);
`default_nettype wire

// ===== tb/sv/spse_test_pkg.sv =====
// spse_test_pkg: request and response records used by the testbench
package spse_test_pkg;
   import spse_pkg::*;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [NODE_W-1:0]   first_node;
      logic [NODE_W-1:0]   second_node;
      logic [WEIGHT_W-1:0] edge_weight;
   } request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [NODE_W-1:0]   node_out;
      logic [DIST_W-1:0]   distance;
   } response_type;
endpackage

// ===== tb/sv/shortest_path_search_engine_test.sv =====
// shortest_path_search_engine_test: random and directed check of the graph search engine
module shortest_path_search_engine_test;
   import spse_pkg::*;
   import spse_test_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = DEF_NODE_COUNT;
   localparam int DEGREE = DEF_MAX_DEGREE;
   localparam int STALL_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spse_req_if req_ch ();
   spse_rsp_if rsp_ch ();

   shortest_path_search_engine DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the graph and of the tables left by the last search
   logic [NODE_W-1:0]   edge_to   [NODES*DEGREE];
   logic [WEIGHT_W-1:0] edge_cost [NODES*DEGREE];
   int unsigned         out_degree [NODES];
   logic [DIST_W-1:0]   best_dist [NODES];
   logic [NODE_W-1:0]   via_node  [NODES];
   bit                  via_known [NODES];
   logic [KEY_W-1:0]    frontier  [$];

   request_type  pending_requests [$];
   response_type expected_responses [$];
   int  failures = 0;
   bit  quiet = 1'b0;       // no idling on either side while set
   bit  hold_requests = 1'b0;
   bit  req_accepted = 1'b0;
   int  idle_cycles = 0;

   // smallest (distance, node) key leaves the frontier first
   function automatic logic [KEY_W-1:0] take_nearest();
      int best;
      logic [KEY_W-1:0] k;
      best = 0;
      for (int i = 1; i < frontier.size(); i++)
         if (frontier[i] < frontier[best]) best = i;
      k = frontier[best];
      frontier.delete(best);
      return k;
   endfunction

   function automatic response_type predict_response(request_type r);
      response_type o;
      logic [KEY_W-1:0]  k;
      logic [NODE_W-1:0] u, v;
      logic [DIST_W-1:0] d;
      int unsigned sum;
      o = '0;
      case (r.operation)
         OP_CLEAR: begin
            foreach (out_degree[i]) out_degree[i] = 0;
         end
         OP_ADD: begin
            if (out_degree[r.first_node] >= DEGREE) begin
               o.status = ST_FULL;
            end else begin
               edge_to[r.first_node*DEGREE + out_degree[r.first_node]] = r.second_node;
               edge_cost[r.first_node*DEGREE + out_degree[r.first_node]] = r.edge_weight;
               out_degree[r.first_node]++;
            end
         end
         OP_SEARCH: begin
            foreach (best_dist[i]) begin
               best_dist[i] = UNREACHED;
               via_known[i] = 1'b0;
            end
            frontier.delete();
            best_dist[r.first_node] = '0;
            frontier.push_back({DIST_W'(0), r.first_node});
            while (frontier.size() > 0) begin
               k = take_nearest();
               d = k[KEY_W-1:NODE_W];
               u = k[NODE_W-1:0];
               if (u == r.second_node) break;
               if (d > best_dist[u]) continue;
               for (int e = 0; e < out_degree[u]; e++) begin
                  v = edge_to[u*DEGREE + e];
                  sum = best_dist[u] + edge_cost[u*DEGREE + e];
                  if (sum > SUM_CAP) sum = SUM_CAP;
                  if (sum < best_dist[v]) begin
                     best_dist[v] = sum;
                     via_node[v] = u;
                     via_known[v] = 1'b1;
                     frontier.push_back({DIST_W'(sum), v});
                  end
               end
            end
            if (best_dist[r.second_node] < UNREACHED) begin
               o.distance = best_dist[r.second_node];
            end else begin
               o.status = ST_UNREACH;
               o.distance = UNREACHED;
            end
         end
         default: begin
            o.distance = best_dist[r.first_node];
            if (via_known[r.first_node]) o.node_out = via_node[r.first_node];
            else o.status = ST_NOPRED;
         end
      endcase
      return o;
   endfunction

   function automatic request_type make_request(logic [OP_W-1:0] op, int a, int b, int w);
      request_type r;
      r.operation = op;
      r.first_node = NODE_W'(a);
      r.second_node = NODE_W'(b);
      r.edge_weight = WEIGHT_W'(w);
      return r;
   endfunction

   // small random graph on a window of nodes, then searches and path reads
   task automatic queue_graph_round(int base, int span, int edges, int searches);
      int w;
      pending_requests.push_back(make_request(OP_CLEAR, $urandom, $urandom, $urandom));
      for (int i = 0; i < edges; i++) begin
         w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
         pending_requests.push_back(make_request(OP_ADD, base + $urandom_range(0, span-1),
            base + $urandom_range(0, span-1), w));
      end
      for (int s = 0; s < searches; s++) begin
         pending_requests.push_back(make_request(OP_SEARCH, base + $urandom_range(0, span-1),
            base + $urandom_range(0, span-1), $urandom));
         for (int i = 0; i < 3; i++)
            pending_requests.push_back(make_request(OP_READ,
               base + $urandom_range(0, span-1), $urandom, $urandom));
      end
   endtask

   // driver: requests change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_accepted) begin
         // request held until taken
      end else if (pending_requests.size() > 0 && !hold_requests
                   && (quiet || $urandom_range(0, 99) >= 9)) begin
         req_ch.valid <= 1'b1;
         {req_ch.operation, req_ch.first_node, req_ch.second_node, req_ch.edge_weight}
            <= pending_requests[0];
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   always @(negedge clock)
      rsp_ch.ready <= !reset && (quiet || $urandom_range(0, 99) >= 9);

   // monitor: sample both channels on the rising edge
   always @(posedge clock) begin
      request_type  taken;
      response_type seen, want;
      if (!reset) begin
         req_accepted <= req_ch.valid && req_ch.ready;
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (req_ch.valid && req_ch.ready) begin
            taken = {req_ch.operation, req_ch.first_node, req_ch.second_node,
                     req_ch.edge_weight};
            void'(pending_requests.pop_front());
            expected_responses.push_back(predict_response(taken));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = {rsp_ch.status, rsp_ch.node_out, rsp_ch.distance};
            if (expected_responses.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               want = expected_responses.pop_front();
               if (seen.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, seen.status);
                  failures++;
               end
               if (seen.node_out !== want.node_out) begin
                  $error("node_out expected %0d actual %0d", want.node_out, seen.node_out);
                  failures++;
               end
               if (seen.distance !== want.distance) begin
                  $error("distance expected %0d actual %0d", want.distance, seen.distance);
                  failures++;
               end
            end
         end
         if (idle_cycles > STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.operation = OP_CLEAR;
      req_ch.first_node = '0;
      req_ch.second_node = '0;
      req_ch.edge_weight = '0;
      rsp_ch.ready = 1'b0;
      foreach (out_degree[i]) begin
         out_degree[i] = 0;
         best_dist[i] = UNREACHED;
         via_known[i] = 1'b0;
         via_node[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: unread tables, extremes, full slots, start equals target
      pending_requests.push_back(make_request(OP_READ, 1023, 0, 0));
      pending_requests.push_back(make_request(OP_SEARCH, 1023, 0, 65535));
      pending_requests.push_back(make_request(OP_ADD, 0, 1023, 65535));
      pending_requests.push_back(make_request(OP_ADD, 1023, 0, 0));
      for (int i = 0; i < 9; i++)   // ninth add finds the slots full
         pending_requests.push_back(make_request(OP_ADD, 5, 6 + i, 100 * i));
      pending_requests.push_back(make_request(OP_SEARCH, 0, 0, 0));
      pending_requests.push_back(make_request(OP_SEARCH, 0, 1023, 0));
      pending_requests.push_back(make_request(OP_READ, 1023, 0, 0));
      pending_requests.push_back(make_request(OP_READ, 0, 0, 0));
      pending_requests.push_back(make_request(OP_SEARCH, 5, 12, 0));
      pending_requests.push_back(make_request(OP_READ, 12, 0, 0));
      pending_requests.push_back(make_request(OP_READ, 600, 0, 0));
      pending_requests.push_back(make_request(OP_SEARCH, 12, 5, 0));
      pending_requests.push_back(make_request(OP_CLEAR, 1023, 1023, 65535));
      pending_requests.push_back(make_request(OP_READ, 12, 1023, 65535));
      pending_requests.push_back(make_request(OP_SEARCH, 5, 12, 0));

      // pause the sender until everything outstanding has answered
      wait (pending_requests.size() == 0);
      hold_requests = 1'b1;
      wait (expected_responses.size() == 0);
      hold_requests = 1'b0;

      // random: mostly small graphs in random windows, one stretch with no idling
      for (int round = 0; round < 7; round++) begin
         quiet = (round == 3);
         queue_graph_round($urandom_range(0, NODES - 16), $urandom_range(2, 12),
            $urandom_range(4, 12), 2);
         wait (pending_requests.size() == 0);
      end
      quiet = 1'b0;
      wait (expected_responses.size() == 0);
      repeat (50) @(posedge clock);
      if (failures == 0 && expected_responses.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
design/spse_pkg.sv
design/spse_if.sv
design/spse_ram.sv
design/spse_heap.sv
design/shortest_path_search_engine.sv
design/spse_checker.sv
tb/sv/spse_test_pkg.sv
tb/sv/shortest_path_search_engine_test.sv
